>>> rtl/ssd_pkg.sv
// ssd_pkg: shared types, codes, constants and the font table for the
// seven segment scan display. No dependencies; all files but ssd_if use it.

package ssd_pkg;

    // request operation codes
    typedef enum logic [1:0] {
        OP_INIT      = 2'd0,
        OP_SET_DIGITS = 2'd1,
        OP_SET_TEMP  = 2'd2,
        OP_REFRESH   = 2'd3
    } op_t;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SEG_ACTIVE_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIG_ACTIVE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_FIRST    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_INTERVAL = 2'd3;

    localparam logic [15:0] REFRESH_INTERVAL_RST = 16'd2;

    // digit code layout
    localparam logic [7:0] BLANK_CODE = 8'd16;
    localparam logic [7:0] DP_MASK    = 8'h80;
    localparam int         DIGIT_COUNT = 4;

    // temperature clamp and reciprocal constants for the decimal split
    localparam logic [13:0] TEMP_MAX  = 14'd9999;
    localparam int          RECIP_10   = 6554;   // 2^16 / 10, rounded up
    localparam int          RECIP_100  = 5243;   // 2^19 / 100, rounded up
    localparam int          RECIP_1000 = 8389;   // 2^23 / 1000, rounded up

    // default depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // classified command handed from front to back
    typedef struct packed {
        op_t              op;
        logic [3:0][7:0]  codes;     // raw codes, position 0 in [0]
        logic [13:0]      tval;      // clamped temperature in tenths
        logic [9:0]       q10;       // tval / 10
        logic [6:0]       q100;      // tval / 100
        logic [3:0]       q1000;     // tval / 1000
        logic [31:0]      now_ms;
    } cmd_t;

    // configuration register set
    typedef struct packed {
        logic        seg_active_high;
        logic        dig_active_high;
        logic        select_first;
        logic [15:0] refresh_interval;
    } cfg_t;

    // font lookup, indexes past the end show no segments
    function automatic logic [7:0] font_lookup(input logic [6:0] idx);
        logic [7:0] seg;
        case (idx)
            7'd0:  seg = 8'h3F;
            7'd1:  seg = 8'h06;
            7'd2:  seg = 8'h5B;
            7'd3:  seg = 8'h4F;
            7'd4:  seg = 8'h66;
            7'd5:  seg = 8'h6D;
            7'd6:  seg = 8'h7D;
            7'd7:  seg = 8'h07;
            7'd8:  seg = 8'h7F;
            7'd9:  seg = 8'h6F;
            7'd10: seg = 8'h77;
            7'd11: seg = 8'h7C;
            7'd12: seg = 8'h39;
            7'd13: seg = 8'h5E;
            7'd14: seg = 8'h79;
            7'd15: seg = 8'h71;
            7'd16: seg = 8'h00;
            7'd17: seg = 8'h40;
            7'd18: seg = 8'h3D;
            7'd19: seg = 8'h76;
            7'd20: seg = 8'h30;
            7'd21: seg = 8'h1E;
            7'd22: seg = 8'h38;
            7'd23: seg = 8'h54;
            7'd24: seg = 8'h3F;
            7'd25: seg = 8'h73;
            7'd26: seg = 8'h67;
            7'd27: seg = 8'h50;
            7'd28: seg = 8'h6D;
            7'd29: seg = 8'h78;
            7'd30: seg = 8'h3E;
            7'd31: seg = 8'h6E;
            7'd32: seg = 8'h5B;
            7'd33: seg = 8'h63;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

>>> rtl/ssd_if.sv
// ssd_if: valid/ready channel interfaces for requests and results.
// Depends on nothing but plain logic types.

interface ssd_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [7:0]         code_right;
    logic [7:0]         code_mid_right;
    logic [7:0]         code_mid_left;
    logic [7:0]         code_left;
    logic signed [14:0] temperature;
    logic [31:0]        now_ms;

    modport source (
        output valid, op, code_right, code_mid_right, code_mid_left, code_left,
               temperature, now_ms,
        input  ready
    );
    modport sink (
        input  valid, op, code_right, code_mid_right, code_mid_left, code_left,
               temperature, now_ms,
        output ready
    );
endinterface

interface ssd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_first;
    logic [7:0] tx_second;
    logic [1:0] position;

    modport source (
        output valid, tx_first, tx_second, position,
        input  ready
    );
    modport sink (
        input  valid, tx_first, tx_second, position,
        output ready
    );
endinterface

>>> rtl/ssd_front.sv
// ssd_front: takes requests, decodes the op, clamps the temperature and
// forms its decimal quotients. Depends on ssd_pkg and ssd_req_if.

module ssd_front (
    ssd_req_if.sink         req_in,
    output logic            push_valid,
    input  logic            push_ready,
    output ssd_pkg::cmd_t   push_cmd
);

    logic [13:0] tval;
    logic [26:0] prod10;
    logic [26:0] prod100;
    logic [26:0] prod1000;

    // clamp to 0..9999, negative values go to zero
    always_comb
    begin
        if (req_in.temperature[14])
            tval = '0;
        else if (req_in.temperature[13:0] > ssd_pkg::TEMP_MAX)
            tval = ssd_pkg::TEMP_MAX;
        else
            tval = req_in.temperature[13:0];
    end

    // quotients by reciprocal multiply, exact for the clamped range
    assign prod10   = 27'(tval) * 27'(ssd_pkg::RECIP_10);
    assign prod100  = 27'(tval) * 27'(ssd_pkg::RECIP_100);
    assign prod1000 = 27'(tval) * 27'(ssd_pkg::RECIP_1000);

    // command for the queue
    always_comb
    begin
        push_cmd.op     = ssd_pkg::op_t'(req_in.op);
        push_cmd.codes  = {req_in.code_left, req_in.code_mid_left,
                           req_in.code_mid_right, req_in.code_right};
        push_cmd.tval   = tval;
        push_cmd.q10    = prod10[25:16];
        push_cmd.q100   = prod100[25:19];
        push_cmd.q1000  = prod1000[26:23];
        push_cmd.now_ms = req_in.now_ms;
    end

    assign push_valid   = req_in.valid;
    assign req_in.ready = push_ready;

endmodule

>>> rtl/ssd_queue.sv
// ssd_queue: short register queue of classified commands between the
// front and the back. Depends on ssd_pkg.

module ssd_queue #(
    parameter int DEPTH = ssd_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  ssd_pkg::cmd_t   push_cmd,
    output logic            pop_valid,
    input  logic            pop_ready,
    output ssd_pkg::cmd_t   pop_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ssd_pkg::cmd_t      mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push_fire;
    logic               pop_fire;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            if (wr_ptr_reg == PTR_W'(DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (pop_fire)
        begin
            if (rd_ptr_reg == PTR_W'(DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (push_fire && !pop_fire)
            count_next = count_reg + CNT_W'(1);
        else if (pop_fire && !push_fire)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push_fire)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    // fill count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    // a lone push grows the count by one
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push_fire && !pop_fire) |=> (count_reg == CNT_W'($past(count_reg) + CNT_W'(1))))
        else $error("queue count missed a push");

endmodule

>>> rtl/ssd_back.sv
// ssd_back: executes queued commands on the digit buffer and scan state,
// holds the configuration and the result register. Depends on ssd_pkg
// and ssd_res_if.

module ssd_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ssd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ssd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  ssd_pkg::cmd_t                   pop_cmd,
    ssd_res_if.source                       res_out
);

    ssd_pkg::cfg_t      cfg_reg, cfg_next;
    logic [3:0][7:0]    codes_reg, codes_next;
    logic [1:0]         scan_pos_reg, scan_pos_next;
    logic [31:0]        last_ms_reg, last_ms_next;
    logic               enabled_reg, enabled_next;
    logic               res_valid_reg, res_valid_next;
    logic [7:0]         tx_first_reg, tx_first_next;
    logic [7:0]         tx_second_reg, tx_second_next;
    logic [1:0]         position_reg, position_next;

    logic               pop_fire;
    logic               fire;
    logic [31:0]        elapsed;
    logic [7:0]         cur_code;
    logic [7:0]         seg;
    logic [7:0]         sel;
    logic [13:0]        d_full;
    logic [9:0]         u_full;
    logic [6:0]         t_full;
    logic [3:0][7:0]    temp_codes;

    assign pop_ready = !res_valid_reg || res_out.ready;
    assign pop_fire  = pop_valid && pop_ready;

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ssd_pkg::CFG_SEG_ACTIVE_HIGH:  cfg_next.seg_active_high = cfg_wdata[0];
                ssd_pkg::CFG_DIG_ACTIVE_HIGH:  cfg_next.dig_active_high = cfg_wdata[0];
                ssd_pkg::CFG_SELECT_FIRST:     cfg_next.select_first    = cfg_wdata[0];
                ssd_pkg::CFG_REFRESH_INTERVAL: cfg_next.refresh_interval = cfg_wdata;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    // decimal remainders from the front's quotients
    always_comb
    begin
        d_full = pop_cmd.tval - 14'({pop_cmd.q10, 3'b000}) - 14'({pop_cmd.q10, 1'b0});
        u_full = pop_cmd.q10 - {pop_cmd.q100, 3'b000} - 10'({pop_cmd.q100, 1'b0});
        t_full = pop_cmd.q100 - {pop_cmd.q1000, 3'b000} - 7'({pop_cmd.q1000, 1'b0});
        temp_codes[0] = {4'b0000, d_full[3:0]};
        temp_codes[1] = ssd_pkg::DP_MASK | {4'b0000, u_full[3:0]};
        if (pop_cmd.tval < 14'd100)
        begin
            temp_codes[2] = ssd_pkg::BLANK_CODE;
            temp_codes[3] = ssd_pkg::BLANK_CODE;
        end
        else if (pop_cmd.tval < 14'd1000)
        begin
            temp_codes[2] = {4'b0000, t_full[3:0]};
            temp_codes[3] = ssd_pkg::BLANK_CODE;
        end
        else
        begin
            temp_codes[2] = {4'b0000, t_full[3:0]};
            temp_codes[3] = {4'b0000, pop_cmd.q1000};
        end
    end

    // refresh timing and byte formation
    always_comb
    begin
        elapsed  = pop_cmd.now_ms - last_ms_reg;
        fire     = pop_fire && (pop_cmd.op == ssd_pkg::OP_REFRESH) && enabled_reg
                   && (elapsed >= {16'd0, cfg_reg.refresh_interval});
        cur_code = codes_reg[scan_pos_reg];
        seg      = ssd_pkg::font_lookup(cur_code[6:0]) | (cur_code & ssd_pkg::DP_MASK);
        if (!cfg_reg.seg_active_high)
            seg = ~seg;
        sel = 8'b0000_0001 << scan_pos_reg;
        if (!cfg_reg.dig_active_high)
            sel = ~sel;
    end

    // state and result register update
    always_comb
    begin
        codes_next     = codes_reg;
        scan_pos_next  = scan_pos_reg;
        last_ms_next   = last_ms_reg;
        enabled_next   = enabled_reg;
        res_valid_next = res_valid_reg && !res_out.ready;
        tx_first_next  = tx_first_reg;
        tx_second_next = tx_second_reg;
        position_next  = position_reg;
        if (pop_fire)
        begin
            case (pop_cmd.op)
                ssd_pkg::OP_INIT:
                begin
                    codes_next    = {ssd_pkg::DIGIT_COUNT{ssd_pkg::BLANK_CODE}};
                    scan_pos_next = '0;
                    enabled_next  = 1'b1;
                end
                ssd_pkg::OP_SET_DIGITS: codes_next = pop_cmd.codes;
                ssd_pkg::OP_SET_TEMP:   codes_next = temp_codes;
                ssd_pkg::OP_REFRESH:
                begin
                    if (fire)
                    begin
                        last_ms_next   = pop_cmd.now_ms;
                        scan_pos_next  = scan_pos_reg + 2'd1;
                        res_valid_next = 1'b1;
                        tx_first_next  = cfg_reg.select_first ? sel : seg;
                        tx_second_next = cfg_reg.select_first ? seg : sel;
                        position_next  = scan_pos_reg;
                    end
                end
                default: codes_next = codes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seg_active_high  <= 1'b0;
            cfg_reg.dig_active_high  <= 1'b1;
            cfg_reg.select_first     <= 1'b0;
            cfg_reg.refresh_interval <= ssd_pkg::REFRESH_INTERVAL_RST;
            codes_reg     <= {ssd_pkg::DIGIT_COUNT{ssd_pkg::BLANK_CODE}};
            scan_pos_reg  <= '0;
            last_ms_reg   <= '0;
            enabled_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            codes_reg     <= codes_next;
            scan_pos_reg  <= scan_pos_next;
            last_ms_reg   <= last_ms_next;
            enabled_reg   <= enabled_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        tx_first_reg  <= tx_first_next;
        tx_second_reg <= tx_second_next;
        position_reg  <= position_next;
    end

    assign res_out.valid     = res_valid_reg;
    assign res_out.tx_first  = tx_first_reg;
    assign res_out.tx_second = tx_second_reg;
    assign res_out.position  = position_reg;

    // a new result only follows a refresh request taken from the queue
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |->
            $past(pop_valid && pop_ready && (pop_cmd.op == ssd_pkg::OP_REFRESH)))
        else $error("result without a refresh request");

    // a fired refresh records its time
    a_last_time: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (last_ms_reg == $past(pop_cmd.now_ms)))
        else $error("refresh time not recorded");

    // a fired refresh moves the scan to the next position
    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (scan_pos_reg == 2'($past(scan_pos_reg) + 2'd1))
                 && (position_reg == $past(scan_pos_reg)))
        else $error("scan position did not advance");

endmodule

>>> rtl/seven_segment_scan_display.sv
// seven_segment_scan_display: top level of the four digit scan driver.
// Depends on ssd_pkg, ssd_if, ssd_front, ssd_queue and ssd_back.
//
//   channel   direction  carries
//   req_in    sink       op, four digit codes, temperature, now_ms
//   res_out   source     tx_first, tx_second, position
//   cfg_*     write      cfg_we, cfg_index, cfg_wdata (16 bits)
//
// One request is taken per cycle; while the result is not stalled, the back
// executes one queued command per cycle, so the sustained rate is one
// request per clock. A taken refresh request passes through a queue entry,
// then the result register.
// Reset is asynchronous and needs no clearing pass; the buffer resets blank.
// A stalled result holds the back; requests keep flowing until the
// QUEUE_DEPTH entry queue fills.

module seven_segment_scan_display #(
    parameter int QUEUE_DEPTH = ssd_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    ssd_req_if.sink                         req_in,
    ssd_res_if.source                       res_out,
    input  logic                            cfg_we,
    input  logic [ssd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ssd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic           push_valid;
    logic           push_ready;
    ssd_pkg::cmd_t  push_cmd;
    logic           pop_valid;
    logic           pop_ready;
    ssd_pkg::cmd_t  pop_cmd;

    // request decode and temperature split
    ssd_front u_front (
        .req_in     (req_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // command queue
    ssd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // execution and result register
    ssd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .res_out   (res_out)
    );

endmodule
